// ===== rtl/core/tcpq_pkg.sv =====
package tcpq_pkg;

	localparam int DEF_CAPACITY = 64;
	localparam int DEF_TAG_BITS = 32;

	localparam int PRIO_W      = 2;
	localparam int TAG_W       = 32;
	localparam int OCC_W       = 7;
	localparam int STATUS_W    = 2;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 48;
	localparam int NUM_CLASSES = 3;

	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	localparam logic [PRIO_W-1:0] CLS_NONE = 2'd0;
	localparam logic [PRIO_W-1:0] CLS_STEP = 2'd1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_BAD_CLASS = 2'd3
	} status_t;

	typedef enum logic {
		CS_IDLE,
		CS_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic commit;
	} cmd_t;

endpackage

// ===== rtl/core/three_class_priority_queue.sv =====
// channel  direction  tdata                                          tuser
// s_axis   in         [1:0] priority_req, [33:2] tag                 [0] action
// m_axis   out        [1:0] out_priority, [33:2] out_tag,            [1:0] status
//                     [40:34] occupancy
// the accept cycle reads the link and tag memories, and the commit follows in the EXEC
// state, since the read of the link memory is registered
// a new word is taken while a finished result still waits in the output register
// a result held back by m_axis_tready stalls the commit, and so the input too
// asynchronous reset clears all control state; the memories need no clearing pass
module three_class_priority_queue
	import tcpq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int TAG_BITS = DEF_TAG_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // priority_req, tag, zero fill
	input  logic                 s_axis_tuser,  // action
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // out_priority, out_tag, occupancy, zero fill
	output logic [STATUS_W-1:0]  m_axis_tuser   // status
);

	localparam int TAG_LO = PRIO_W;
	localparam int USED_W = PRIO_W + TAG_W + OCC_W;

	cmd_t              cmd;
	status_t           res_status;
	logic [PRIO_W-1:0] res_priority;
	logic [TAG_W-1:0]  res_tag;
	logic [OCC_W-1:0]  res_occupancy;

	tcpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	tcpq_dp #(
		.CAPACITY (CAPACITY),
		.TAG_BITS (TAG_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.in_action     (s_axis_tuser),
		.in_priority   (s_axis_tdata[PRIO_W-1:0]),
		.in_tag        (s_axis_tdata[TAG_LO +: TAG_W]),
		.res_status    (res_status),
		.res_priority  (res_priority),
		.res_tag       (res_tag),
		.res_occupancy (res_occupancy)
	);

	assign m_axis_tdata = {{(M_TDATA_W - USED_W){1'b0}}, res_occupancy, res_tag, res_priority};
	assign m_axis_tuser = res_status;

endmodule

// ===== rtl/core/tcpq_ram.sv =====
module tcpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/tcpq_ctrl.sv =====
module tcpq_ctrl
	import tcpq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        can_load;

	assign can_load = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (in_valid) begin
					state_d = CS_EXEC;
				end
			end
			CS_EXEC: begin
				if (can_load) begin
					state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			CS_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			CS_EXEC: begin
				cmd.commit = can_load;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_commit_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("result register not loaded after commit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !cmd.commit)
		else $error("pending word overwritten");
`endif

endmodule

// ===== rtl/core/tcpq_dp.sv =====
module tcpq_dp
	import tcpq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int TAG_BITS = DEF_TAG_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic              in_action,
	input  logic [PRIO_W-1:0] in_priority,
	input  logic [TAG_W-1:0]  in_tag,
	output status_t           res_status,
	output logic [PRIO_W-1:0] res_priority,
	output logic [TAG_W-1:0]  res_tag,
	output logic [OCC_W-1:0]  res_occupancy
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic              act_q;
	logic [PRIO_W-1:0] cls_q;
	logic [TAG_W-1:0]  tag_q;

	logic [IW-1:0]          class_head_q [NUM_CLASSES];
	logic [IW-1:0]          class_tail_q [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] nonempty_q;
	logic [IW-1:0]          free_head_q;
	logic [CW-1:0]          free_cnt_q;
	logic [CW-1:0]          fresh_q;
	logic [CW-1:0]          entry_q;

	logic                tag_we;
	logic                link_we;
	logic [IW-1:0]       link_waddr;
	logic [IW-1:0]       link_wdata;
	logic [IW-1:0]       link_raddr;
	logic [IW-1:0]       link_rdata;
	logic [TAG_BITS-1:0] tag_wdata;
	logic [TAG_BITS-1:0] tag_rdata;
	logic [TAG_W-1:0]    tag_rd_ext;
	logic [OCC_W-1:0]    occ_d;

	logic              is_enq;
	logic              enq_ok;
	logic              deq_ok;
	logic              from_free;
	logic [IW-1:0]     slot;
	logic [PRIO_W-1:0] c_deq;
	logic [PRIO_W-1:0] c_enq;
	logic [CW-1:0]     entry_d;
	status_t           status_d;
	logic [PRIO_W-1:0] prio_d;
	logic [TAG_W-1:0]  tag_d;

	generate
		if (TAG_BITS == TAG_W) begin : g_tag_eq
			assign tag_wdata  = tag_q;
			assign tag_rd_ext = tag_rdata;
		end else if (TAG_BITS > TAG_W) begin : g_tag_wide
			assign tag_wdata  = {{(TAG_BITS - TAG_W){1'b0}}, tag_q};
			assign tag_rd_ext = tag_rdata[TAG_W-1:0];
		end else begin : g_tag_narrow
			assign tag_wdata  = tag_q[TAG_BITS-1:0];
			assign tag_rd_ext = {{(TAG_W - TAG_BITS){1'b0}}, tag_rdata};
		end
		if (CW == OCC_W) begin : g_occ_eq
			assign occ_d = entry_d;
		end else if (CW > OCC_W) begin : g_occ_wide
			assign occ_d = entry_d[OCC_W-1:0];
		end else begin : g_occ_narrow
			assign occ_d = {{(OCC_W - CW){1'b0}}, entry_d};
		end
	endgenerate

	always_comb begin
		if (nonempty_q[0]) begin
			c_deq = 2'd0;
		end else if (nonempty_q[1]) begin
			c_deq = 2'd1;
		end else begin
			c_deq = 2'd2;
		end
	end

	always_comb begin
		is_enq    = act_q == ACT_ENQ;
		c_enq     = cls_q - CLS_STEP;
		from_free = free_cnt_q != '0;
		slot      = from_free ? free_head_q : fresh_q[IW-1:0];
		enq_ok    = is_enq && (cls_q != CLS_NONE) && (entry_q != CW'(CAPACITY));
		deq_ok    = !is_enq && (nonempty_q != '0);

		status_d = ST_OK;
		prio_d   = CLS_NONE;
		tag_d    = '0;
		entry_d  = entry_q;
		if (is_enq) begin
			if (cls_q == CLS_NONE) begin
				status_d = ST_BAD_CLASS;
			end else if (!enq_ok) begin
				status_d = ST_FULL;
			end else begin
				entry_d = entry_q + CW'(1);
			end
		end else if (!deq_ok) begin
			status_d = ST_EMPTY;
		end else begin
			prio_d  = c_deq + CLS_STEP;
			tag_d   = tag_rd_ext;
			entry_d = entry_q - CW'(1);
		end

		tag_we     = cmd.commit && enq_ok;
		link_we    = cmd.commit && ((enq_ok && nonempty_q[c_enq]) || deq_ok);
		link_waddr = is_enq ? class_tail_q[c_enq] : class_head_q[c_deq];
		link_wdata = is_enq ? slot : free_head_q;
		link_raddr = (in_action == ACT_DEQ) ? class_head_q[c_deq] : free_head_q;
	end

	tcpq_ram #(
		.WIDTH (TAG_BITS),
		.DEPTH (CAPACITY)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (slot),
		.wdata (tag_wdata),
		.re    (cmd.accept),
		.raddr (class_head_q[c_deq]),
		.rdata (tag_rdata)
	);

	tcpq_ram #(
		.WIDTH (IW),
		.DEPTH (CAPACITY)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (cmd.accept),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q <= in_action;
			cls_q <= in_priority;
			tag_q <= in_tag;
		end
		if (cmd.commit) begin
			res_status    <= status_d;
			res_priority  <= prio_d;
			res_tag       <= tag_d;
			res_occupancy <= occ_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				class_head_q[i] <= '0;
				class_tail_q[i] <= '0;
			end
			nonempty_q  <= '0;
			free_head_q <= '0;
			free_cnt_q  <= '0;
			fresh_q     <= '0;
			entry_q     <= '0;
		end else if (cmd.commit) begin
			entry_q <= entry_d;
			if (enq_ok) begin
				if (!nonempty_q[c_enq]) begin
					class_head_q[c_enq] <= slot;
					nonempty_q[c_enq]   <= 1'b1;
				end
				class_tail_q[c_enq] <= slot;
				if (from_free) begin
					free_head_q <= link_rdata;
					free_cnt_q  <= free_cnt_q - CW'(1);
				end else begin
					fresh_q <= fresh_q + CW'(1);
				end
			end else if (deq_ok) begin
				if (class_head_q[c_deq] == class_tail_q[c_deq]) begin
					nonempty_q[c_deq] <= 1'b0;
				end else begin
					class_head_q[c_deq] <= link_rdata;
				end
				free_head_q <= class_head_q[c_deq];
				free_cnt_q  <= free_cnt_q + CW'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(entry_q + free_cnt_q) == fresh_q)
		else $error("slot accounting out of balance");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_empty_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(entry_q == '0) == (nonempty_q == '0))
		else $error("class flags disagree with entry count");
`endif

endmodule

// ===== sim/tcpq_checker.sv =====
module tcpq_checker
	import tcpq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // priority_req, tag, zero fill
	input  logic                 s_axis_tuser,  // action
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [M_TDATA_W-1:0] m_axis_tdata,  // out_priority, out_tag, occupancy, zero fill
	input  logic [STATUS_W-1:0]  m_axis_tuser,  // status
	output int                   fail_count,
	output int                   outstanding
);

	localparam int SLOT_W = $clog2(DEF_CAPACITY);
	localparam int TAG_LO = PRIO_W;
	localparam int OCC_LO = PRIO_W + TAG_W;

	typedef struct packed {
		status_t           status;
		logic [PRIO_W-1:0] cls;
		logic [TAG_W-1:0]  tag;
		logic [OCC_W-1:0]  occ;
	} result_t;

	logic [TAG_W-1:0]  tag_mem [DEF_CAPACITY];
	logic [SLOT_W-1:0] link_mem [DEF_CAPACITY];
	logic [SLOT_W-1:0] head [NUM_CLASSES];
	logic [SLOT_W-1:0] tail [NUM_CLASSES];
	logic              busy_cls [NUM_CLASSES];
	logic [SLOT_W-1:0] free_top;
	int                free_len;
	int                unused_next;
	int                held;
	int                mismatches;
	result_t           result_q [$];

	function automatic result_t queue_step(input logic act, input logic [PRIO_W-1:0] cls,
			input logic [TAG_W-1:0] tag);
		result_t           r;
		logic [SLOT_W-1:0] s;
		int                c;
		r.status = ST_OK;
		r.cls    = CLS_NONE;
		r.tag    = '0;
		if (act == ACT_ENQ) begin
			if (cls == CLS_NONE) begin
				r.status = ST_BAD_CLASS;
			end else if (held >= DEF_CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				c = int'(cls - CLS_STEP);
				// returned slots first, then never-used ones
				if (free_len > 0) begin
					s        = free_top;
					free_top = link_mem[s];
					free_len--;
				end else begin
					s = SLOT_W'(unused_next);
					unused_next++;
				end
				tag_mem[s]  = tag;
				link_mem[s] = '0;
				if (busy_cls[c]) begin
					link_mem[tail[c]] = s;
				end else begin
					head[c]     = s;
					busy_cls[c] = 1'b1;
				end
				tail[c] = s;
				held++;
			end
		end else begin
			c = 0;
			while (c < NUM_CLASSES && !busy_cls[c])
				c++;
			if (c == NUM_CLASSES) begin
				r.status = ST_EMPTY;
			end else begin
				s     = head[c];
				r.cls = CLS_STEP + PRIO_W'(c);
				r.tag = tag_mem[s];
				if (s == tail[c])
					busy_cls[c] = 1'b0;
				else
					head[c] = link_mem[s];
				link_mem[s] = free_top;
				free_top    = s;
				free_len++;
				held--;
			end
		end
		r.occ = OCC_W'(held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head[c]     = '0;
				tail[c]     = '0;
				busy_cls[c] = 1'b0;
			end
			free_top    = '0;
			free_len    = 0;
			unused_next = 0;
			held        = 0;
			mismatches  = 0;
			result_q.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			// result words first: a word taken this edge cannot answer itself
			if (m_axis_tvalid && m_axis_tready) begin
				if (result_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tcpq: unexpected result word status %0d class %0d tag %h occ %0d",
							m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[TAG_LO +: TAG_W],
							m_axis_tdata[OCC_LO +: OCC_W]);
				end else begin
					want = result_q.pop_front();
					if (m_axis_tuser !== want.status || m_axis_tdata[1:0] !== want.cls ||
							m_axis_tdata[TAG_LO +: TAG_W] !== want.tag ||
							m_axis_tdata[OCC_LO +: OCC_W] !== want.occ) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("tcpq: mismatch, expected status %0d class %0d tag %h occ %0d,",
								want.status, want.cls, want.tag, want.occ);
							$display(" got status %0d class %0d tag %h occ %0d",
								m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[TAG_LO +: TAG_W],
								m_axis_tdata[OCC_LO +: OCC_W]);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				result_q.push_back(queue_step(s_axis_tuser, s_axis_tdata[1:0],
					s_axis_tdata[TAG_LO +: TAG_W]));
			fail_count  <= mismatches;
			outstanding <= result_q.size();
		end
	end

endmodule

// ===== sim/tb_three_class_priority_queue.sv =====
module tb_three_class_priority_queue;
	import tcpq_pkg::*;

	localparam int RANDOM_WORDS = 1530;
	localparam int HOLD_CYCLES  = 400;
	localparam int WATCHDOG     = 5000;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [PRIO_W-1:0] CLS_HI  = 2'd1;
	localparam logic [PRIO_W-1:0] CLS_MID = 2'd2;
	localparam logic [PRIO_W-1:0] CLS_LO  = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic                 s_axis_tuser = ACT_ENQ;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]  m_axis_tuser;
	int                   fail_count;
	int                   outstanding;
	int                   quiet_cycles = 0;
	bit                   hold_go = 1'b0;
	bit                   hold_done = 1'b0;
	bit                   burst_mode = 1'b0;

	always #6 clk = ~clk;

	three_class_priority_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	tcpq_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("tb_three_class_priority_queue: errors");
			$finish;
		end
	end

	task automatic send_word(input logic act, input logic [PRIO_W-1:0] cls,
			input logic [TAG_W-1:0] tag);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {{(S_TDATA_W-PRIO_W-TAG_W){1'b0}}, tag, cls};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic sender_gap();
		int r;
		int g;
		r = $urandom_range(0, 99);
		if (burst_mode || (hold_go && !hold_done) || r < 50)
			g = 0;
		else if (r < 88)
			g = $urandom_range(1, 3);
		else if (r < 97)
			g = $urandom_range(4, 12);
		else
			g = $urandom_range(20, 60);
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic send_random(input int enq_pct, input int cls_mode);
		logic              act;
		logic [PRIO_W-1:0] cls;
		logic [TAG_W-1:0]  tag;
		int                r;
		act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
		r   = $urandom_range(0, 99);
		if (act == ACT_DEQ)
			cls = PRIO_W'($urandom_range(0, 3));
		else if (r < 4)
			cls = CLS_NONE;
		else if (cls_mode != 0)
			cls = PRIO_W'(cls_mode);
		else
			cls = PRIO_W'($urandom_range(CLS_HI, CLS_LO));
		r = $urandom_range(0, 99);
		if (r < 4)
			tag = '0;
		else if (r < 8)
			tag = '1;
		else
			tag = TAG_W'($urandom);
		send_word(act, cls, tag);
	endtask

	// result side
	initial begin
		int r;
		int n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_go && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				if (r < 55) begin
					m_axis_tready <= 1'b1;
					n = $urandom_range(1, 12);
				end else if (r < 62) begin
					m_axis_tready <= 1'b1;
					n = $urandom_range(60, 200);
				end else if (r < 94) begin
					m_axis_tready <= 1'b0;
					n = $urandom_range(1, 3);
				end else begin
					m_axis_tready <= 1'b0;
					n = $urandom_range(10, 40);
				end
				repeat (n) @(posedge clk);
			end
		end
	end

	// word side and verdict
	initial begin
		int sent;
		int phase_len;
		int enq_pct;
		int cls_mode;
		int r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty and bad class
		send_word(ACT_DEQ, CLS_LO, '1);                sender_gap();
		send_word(ACT_ENQ, CLS_NONE, 32'h1234_5678);   sender_gap();
		// entries in all three classes, two in the most urgent, served most urgent first
		send_word(ACT_ENQ, CLS_LO, '0);                sender_gap();
		send_word(ACT_ENQ, CLS_MID, '1);               sender_gap();
		send_word(ACT_ENQ, CLS_HI, 32'haaaa_aaaa);     sender_gap();
		send_word(ACT_ENQ, CLS_HI, 32'h5555_5555);     sender_gap();
		send_word(ACT_ENQ, CLS_NONE, '1);              sender_gap();
		send_word(ACT_DEQ, CLS_NONE, '0);              sender_gap();
		send_word(ACT_DEQ, CLS_HI, 32'h5555_5555);     sender_gap();
		send_word(ACT_DEQ, CLS_MID, 32'haaaa_aaaa);    sender_gap();
		send_word(ACT_DEQ, CLS_LO, '1);                sender_gap();
		send_word(ACT_DEQ, CLS_NONE, '0);              sender_gap();
		// slot reuse through the free list
		send_word(ACT_ENQ, CLS_LO, 32'h0000_0001);     sender_gap();
		send_word(ACT_ENQ, CLS_LO, 32'h8000_0000);     sender_gap();
		send_word(ACT_DEQ, CLS_MID, '1);               sender_gap();
		send_word(ACT_ENQ, CLS_MID, 32'h7fff_ffff);    sender_gap();
		send_word(ACT_ENQ, CLS_HI, 32'hfffe_0001);     sender_gap();
		send_word(ACT_DEQ, CLS_HI, '0);                sender_gap();
		send_word(ACT_DEQ, CLS_LO, 32'h0f0f_0f0f);     sender_gap();
		send_word(ACT_DEQ, CLS_NONE, '1);              sender_gap();
		send_word(ACT_DEQ, CLS_MID, '0);               sender_gap();
		send_word(ACT_DEQ, CLS_HI, '1);                sender_gap();

		// phases lean to filling, draining or a balanced mix
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			r          = $urandom_range(0, 2);
			enq_pct    = (r == 0) ? 85 : (r == 1) ? 20 : 55;
			cls_mode   = ($urandom_range(0, 3) == 0) ? $urandom_range(CLS_HI, CLS_LO) : 0;
			burst_mode = ($urandom_range(0, 4) == 0);
			phase_len  = $urandom_range(30, 150);
			for (int k = 0; k < phase_len && sent < RANDOM_WORDS; k++) begin
				if (sent == 200)
					hold_go = 1'b1;
				send_random(enq_pct, cls_mode);
				sent++;
				if (sent == 800)
					wait_drained();
				else
					sender_gap();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("tb_three_class_priority_queue: clean");
		else
			$display("tb_three_class_priority_queue: errors");
		$finish;
	end

endmodule
